FILE: design/tsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the TCP SYN fingerprinter.
// No dependencies; used by tsf_classify, tsf_core and the top level.
package tsf_pkg;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_OPTION = 1'b1
  } tsf_op_e;

  typedef enum logic [2:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_A       = 3'd1,
    CLS_B       = 3'd2,
    CLS_C       = 3'd3,
    CLS_D       = 3'd4,
    CLS_E       = 3'd5
  } tsf_class_e;

  localparam int unsigned NUM_CHECK = 14;
  localparam int unsigned NUM_CLASS = 6;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned TOTAL_W   = 32;

  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [3:0] DOFF_MIN  = 4'd5;
  localparam logic [POS_W-1:0] HDR_BYTES = 6'd20;

  // Offset / value pairs checked against the option bytes.
  localparam logic [POS_W-1:0] CHK_POS [NUM_CHECK] = '{
    6'd0, 6'd4, 6'd4, 6'd5, 6'd5, 6'd6, 6'd6,
    6'd8, 6'd9, 6'd10, 6'd10, 6'd16, 6'd17, 6'd20
  };
  localparam logic [7:0] CHK_VAL [NUM_CHECK] = '{
    8'd2, 8'd1, 8'd4, 8'd1, 8'd3, 8'd4, 8'd8,
    8'd1, 8'd1, 8'd4, 8'd8, 8'd1, 8'd3, 8'd4
  };

  // Required match bits and option lengths of each signature.
  localparam logic [NUM_CHECK-1:0] SIG_A = 14'b00_0000_0010_1011;
  localparam logic [NUM_CHECK-1:0] SIG_B = 14'b00_0011_1001_0011;
  localparam logic [NUM_CHECK-1:0] SIG_C = 14'b10_0101_1001_0011;
  localparam logic [NUM_CHECK-1:0] SIG_D = 14'b01_1000_0100_0101;
  localparam logic [NUM_CHECK-1:0] SIG_E = 14'b01_1000_0100_1011;

  localparam logic [POS_W-1:0] LEN_A  = 6'd8;
  localparam logic [POS_W-1:0] LEN_B  = 6'd12;
  localparam logic [POS_W-1:0] LEN_C  = 6'd24;
  localparam logic [POS_W-1:0] LEN_DE = 6'd20;

  typedef struct packed {
    tsf_op_e    op;
    logic [7:0] protocol;
    logic       syn_flag;
    logic       ack_flag;
    logic [3:0] data_offset;
    logic [7:0] option_byte;
  } tsf_item_t;

  typedef struct packed {
    logic [NUM_CHECK-1:0] bits;
    logic [POS_W-1:0]     pos;
    logic                 last;
    tsf_class_e           os_class;
  } tsf_match_t;

  typedef struct packed {
    tsf_class_e         os_class;
    logic               classified;
    logic [TOTAL_W-1:0] pkt_total;
    logic [TOTAL_W-1:0] tcp_total;
    logic [TOTAL_W-1:0] udp_total;
    logic [TOTAL_W-1:0] class_total;
  } tsf_result_t;

endpackage

FILE: design/tcp_syn_os_fingerprinter_top.sv
`timescale 1ns / 1ps
// Top level of the passive TCP SYN fingerprinter: stream ports, input register, core.
// Depends on tsf_pkg and tsf_core.
//
//  Channel  | Dir | Handshake              | Payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/_tready  | tuser = op, tdata = header or option fields
//  m_axis   | out | m_axis_tvalid/_tready  | tuser = classified, tdata = class + totals
//
// One item per cycle sustained while m_axis_tready is high. An item waits in the
// input register until the core takes it; the core then updates capture state and
// counters and loads the result register, so m_axis_tvalid rises in the cycle after
// the core takes the item. Option bytes outside a capture, and bytes before the last
// of a capture, produce no result. Reset (rst_ni low, asynchronous) clears capture
// state, all counters and both valid flags. With the result register full and
// m_axis_tready low, the input register still takes one item, then stalls.
module tcp_syn_os_fingerprinter_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] protocol, [8] syn_flag, [9] ack_flag, [13:10] data_offset,
  // [21:14] option_byte, [23:22] zero
  input  logic [23:0]  s_axis_tdata,
  // [0] op
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] os_class, [34:3] pkt_total, [66:35] tcp_total, [98:67] udp_total,
  // [130:99] class_total, [135:131] zero
  output logic [135:0] m_axis_tdata,
  // [0] classified
  output logic [0:0]   m_axis_tuser
);

  logic                 in_valid_q, in_valid_d;
  tsf_pkg::tsf_item_t   item_q, item_in;
  logic                 take;
  tsf_pkg::tsf_result_t res;

  // Unpack the slave-side item.
  always_comb begin
    item_in.op          = tsf_pkg::tsf_op_e'(s_axis_tuser[0]);
    item_in.protocol    = s_axis_tdata[7:0];
    item_in.syn_flag    = s_axis_tdata[8];
    item_in.ack_flag    = s_axis_tdata[9];
    item_in.data_offset = s_axis_tdata[13:10];
    item_in.option_byte = s_axis_tdata[21:14];
  end

  // Input register empties when the core takes its item.
  assign s_axis_tready = !in_valid_q || take;

  always_comb begin
    in_valid_d = in_valid_q && !take;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_in;
    end
  end

  tsf_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .take_o       (take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // Pack the master-side item.
  assign m_axis_tdata = {5'b0, res.class_total, res.udp_total, res.tcp_total,
                         res.pkt_total, res.os_class};
  assign m_axis_tuser = res.classified;

endmodule

FILE: design/tsf_classify.sv
`timescale 1ns / 1ps
// Option byte compare and signature pick for one capture step.
// Depends on tsf_pkg.
module tsf_classify (
  input  logic [tsf_pkg::POS_W-1:0]     pos_i,
  input  logic [tsf_pkg::POS_W-1:0]     len_i,
  input  logic [tsf_pkg::NUM_CHECK-1:0] bits_i,
  input  logic [7:0]                    byte_i,
  output tsf_pkg::tsf_match_t           match_o
);

  logic [tsf_pkg::NUM_CHECK-1:0] bits_nx;
  logic [tsf_pkg::POS_W-1:0]     pos_nx;

  always_comb begin
    bits_nx = bits_i;
    for (int k = 0; k < tsf_pkg::NUM_CHECK; k++) begin
      if (pos_i == tsf_pkg::CHK_POS[k] && byte_i == tsf_pkg::CHK_VAL[k]) begin
        bits_nx[k] = 1'b1;
      end
    end
  end

  assign pos_nx = pos_i + 1'b1;

  always_comb begin
    match_o.bits = bits_nx;
    match_o.pos  = pos_nx;
    match_o.last = (pos_nx >= len_i);
    // First listed signature wins.
    if (len_i == tsf_pkg::LEN_A && (bits_nx & tsf_pkg::SIG_A) == tsf_pkg::SIG_A) begin
      match_o.os_class = tsf_pkg::CLS_A;
    end else if (len_i == tsf_pkg::LEN_B && (bits_nx & tsf_pkg::SIG_B) == tsf_pkg::SIG_B) begin
      match_o.os_class = tsf_pkg::CLS_B;
    end else if (len_i == tsf_pkg::LEN_C && (bits_nx & tsf_pkg::SIG_C) == tsf_pkg::SIG_C) begin
      match_o.os_class = tsf_pkg::CLS_C;
    end else if (len_i == tsf_pkg::LEN_DE
                 && (bits_nx & tsf_pkg::SIG_D) == tsf_pkg::SIG_D) begin
      match_o.os_class = tsf_pkg::CLS_D;
    end else if (len_i == tsf_pkg::LEN_DE
                 && (bits_nx & tsf_pkg::SIG_E) == tsf_pkg::SIG_E) begin
      match_o.os_class = tsf_pkg::CLS_E;
    end else begin
      match_o.os_class = tsf_pkg::CLS_UNKNOWN;
    end
  end

endmodule

FILE: design/tsf_core.sv
`timescale 1ns / 1ps
// Capture state, packet and class counters, and the result register.
// Depends on tsf_pkg and tsf_classify.
module tsf_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  tsf_pkg::tsf_item_t  item_i,
  output logic                take_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tsf_pkg::tsf_result_t res_o
);

  localparam int unsigned EXT_W = 64;

  logic                          cap_q, cap_d;
  logic [tsf_pkg::POS_W-1:0]     len_q, len_d;
  logic [tsf_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [tsf_pkg::NUM_CHECK-1:0] bits_q, bits_d;
  logic [COUNT_WIDTH-1:0]        ip_q, ip_d, tcp_q, tcp_d, udp_q, udp_d;
  logic [COUNT_WIDTH-1:0]        cls_cnt_q [tsf_pkg::NUM_CLASS];
  logic [COUNT_WIDTH-1:0]        cls_cnt_d [tsf_pkg::NUM_CLASS];
  logic                          res_valid_q, res_valid_d;
  tsf_pkg::tsf_result_t          res_q, res_d;

  tsf_pkg::tsf_match_t  match;
  tsf_pkg::tsf_class_e  cls_sel;
  logic                 cls_inc;
  logic                 emit;
  logic                 is_hdr;
  logic [COUNT_WIDTH-1:0] cls_new;
  logic [EXT_W-1:0]     ip_ext, tcp_ext, udp_ext, cls_ext;

  tsf_classify u_classify (
    .pos_i   (pos_q),
    .len_i   (len_q),
    .bits_i  (bits_q),
    .byte_i  (item_i.option_byte),
    .match_o (match)
  );

  assign is_hdr = (item_i.op == tsf_pkg::OP_HEADER);
  assign take_o = item_valid_i && (!res_valid_q || res_ready_i);

  always_comb begin
    cap_d   = cap_q;
    len_d   = len_q;
    pos_d   = pos_q;
    bits_d  = bits_q;
    ip_d    = ip_q;
    tcp_d   = tcp_q;
    udp_d   = udp_q;
    cls_sel = tsf_pkg::CLS_UNKNOWN;
    cls_inc = 1'b0;
    emit    = 1'b0;
    if (is_hdr) begin
      emit  = 1'b1;
      cap_d = 1'b0;
      ip_d  = ip_q + 1'b1;
      if (item_i.protocol == tsf_pkg::PROTO_UDP) begin
        udp_d = udp_q + 1'b1;
      end else if (item_i.protocol == tsf_pkg::PROTO_TCP) begin
        tcp_d = tcp_q + 1'b1;
        if (item_i.syn_flag && !item_i.ack_flag) begin
          pos_d  = '0;
          bits_d = '0;
          if (item_i.data_offset >= tsf_pkg::DOFF_MIN) begin
            len_d = {item_i.data_offset, 2'b00} - tsf_pkg::HDR_BYTES;
          end else begin
            len_d = '0;
          end
          if (len_d == '0) begin
            cls_inc = 1'b1;   // no options: unknown right away
          end else begin
            cap_d = 1'b1;
          end
        end
      end
    end else if (cap_q) begin
      bits_d = match.bits;
      pos_d  = match.pos;
      if (match.last) begin
        cap_d   = 1'b0;
        emit    = 1'b1;
        cls_inc = 1'b1;
        cls_sel = match.os_class;
      end
    end
  end

  assign cls_new = cls_cnt_q[cls_sel] + 1'b1;

  always_comb begin
    for (int i = 0; i < tsf_pkg::NUM_CLASS; i++) begin
      cls_cnt_d[i] = cls_cnt_q[i];
    end
    if (cls_inc) begin
      cls_cnt_d[cls_sel] = cls_new;
    end
  end

  assign ip_ext  = EXT_W'(ip_d);
  assign tcp_ext = EXT_W'(tcp_d);
  assign udp_ext = EXT_W'(udp_d);
  assign cls_ext = EXT_W'(cls_new);

  always_comb begin
    res_d.os_class    = cls_sel;
    res_d.classified  = cls_inc;
    res_d.pkt_total   = ip_ext[tsf_pkg::TOTAL_W-1:0];
    res_d.tcp_total   = tcp_ext[tsf_pkg::TOTAL_W-1:0];
    res_d.udp_total   = udp_ext[tsf_pkg::TOTAL_W-1:0];
    res_d.class_total = cls_inc ? cls_ext[tsf_pkg::TOTAL_W-1:0] : '0;
  end

  always_comb begin
    res_valid_d = res_valid_q && !res_ready_i;
    if (take_o) begin
      res_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      bits_q      <= '0;
      ip_q        <= '0;
      tcp_q       <= '0;
      udp_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < tsf_pkg::NUM_CLASS; i++) begin
        cls_cnt_q[i] <= '0;
      end
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        cap_q  <= cap_d;
        len_q  <= len_d;
        pos_q  <= pos_d;
        bits_q <= bits_d;
        ip_q   <= ip_d;
        tcp_q  <= tcp_d;
        udp_q  <= udp_d;
        for (int i = 0; i < tsf_pkg::NUM_CLASS; i++) begin
          cls_cnt_q[i] <= cls_cnt_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A live capture always has bytes left to take.
  a_cap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q |-> (pos_q < len_q))
    else $error("capture position past option length");

  // An item that yields nothing leaves the result register empty.
  a_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !emit) |=> !res_valid_q)
    else $error("stale result after silent item");

  // Every header produces a result.
  a_hdr_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && is_hdr) |=> res_valid_q)
    else $error("header item lost its result");

  // An unfinished result carries no class.
  a_unclass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.classified)
      |-> (res_q.os_class == tsf_pkg::CLS_UNKNOWN && res_q.class_total == '0))
    else $error("class fields set on unclassified result");

endmodule

FILE: sim/tcp_syn_os_fingerprinter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tcp_syn_os_fingerprinter_top: directed and random header and option
// items, an item-level predictor of counters and fingerprint classes, scoreboard on the output.
// Depends on tsf_pkg and the fingerprinter RTL only.
module tcp_syn_os_fingerprinter_top_tb;

  localparam int CNT_W       = 32;
  localparam int N_RANDOM    = 1800;
  localparam int CALM_ITEMS  = 200;   // tail of the run without idling
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 8;

  // One input item plus sender hints.
  typedef struct {
    tsf_pkg::tsf_op_e op;
    logic [7:0] proto;
    logic       syn;
    logic       ack;
    logic [3:0] doff;
    logic [7:0] opt;
    bit         drain;  // hold off until every pending fingerprint has come back
    bit         calm;
  } pkt_event_t;

  typedef struct {
    tsf_pkg::tsf_class_e os_class;
    logic        classified;
    logic [31:0] pkt_total;
    logic [31:0] tcp_total;
    logic [31:0] udp_total;
    logic [31:0] class_total;
  } fp_result_t;

  logic          clk_i;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [23:0]   s_axis_tdata  = '0;
  logic [0:0]    s_axis_tuser  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  tcp_syn_os_fingerprinter_top #(
    .COUNT_WIDTH(CNT_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  pkt_event_t stim_q[$];
  fp_result_t fp_expect_q[$];

  int err_cnt     = 0;
  int n_items     = 0;
  int n_results   = 0;
  int seen_cls[tsf_pkg::NUM_CLASS];
  bit calm_phase  = 0;

  // ---------------------------------------------------------------------------
  // Fingerprint predictor: capture state, option bytes seen so far, counters.
  // ---------------------------------------------------------------------------
  bit             capturing = 0;
  int             opt_len   = 0;
  int             opt_pos   = 0;
  logic [7:0]     cap_buf[64];
  logic [CNT_W-1:0] ip_cnt  = '0;
  logic [CNT_W-1:0] tcp_cnt = '0;
  logic [CNT_W-1:0] udp_cnt = '0;
  logic [CNT_W-1:0] class_cnt[tsf_pkg::NUM_CLASS];

  initial foreach (class_cnt[i]) class_cnt[i] = '0;
  initial foreach (seen_cls[i]) seen_cls[i] = 0;

  // Signature byte required at an option offset, or -1 if the offset is free.
  function automatic int tpl_value(tsf_pkg::tsf_class_e c, int ofs);
    case (c)
      tsf_pkg::CLS_A: case (ofs)
        0: return 2; 4: return 1; 5: return 1; 6: return 4;
        default: return -1;
      endcase
      tsf_pkg::CLS_B: case (ofs)
        0: return 2; 4: return 1; 5: return 3; 8: return 1; 9: return 1; 10: return 4;
        default: return -1;
      endcase
      tsf_pkg::CLS_C: case (ofs)
        0: return 2; 4: return 1; 5: return 3; 8: return 1; 9: return 1; 10: return 8;
        20: return 4;
        default: return -1;
      endcase
      tsf_pkg::CLS_D: case (ofs)
        0: return 2; 4: return 4; 6: return 8; 16: return 1; 17: return 3;
        default: return -1;
      endcase
      tsf_pkg::CLS_E: case (ofs)
        0: return 2; 4: return 1; 5: return 1; 6: return 8; 16: return 1; 17: return 3;
        default: return -1;
      endcase
      default: return -1;
    endcase
  endfunction

  function automatic int sig_len(tsf_pkg::tsf_class_e c);
    case (c)
      tsf_pkg::CLS_A:                 return 8;
      tsf_pkg::CLS_B:                 return 12;
      tsf_pkg::CLS_C:                 return 24;
      tsf_pkg::CLS_D, tsf_pkg::CLS_E: return 20;
      default:                        return 0;
    endcase
  endfunction

  function automatic bit sig_fits(tsf_pkg::tsf_class_e c);
    int v;
    if (opt_len != sig_len(c)) return 0;
    for (int i = 0; i < opt_len; i++) begin
      v = tpl_value(c, i);
      if (v >= 0 && cap_buf[i] != 8'(v)) return 0;
    end
    return 1;
  endfunction

  // First signature in list order wins.
  function automatic tsf_pkg::tsf_class_e pick_class();
    if (sig_fits(tsf_pkg::CLS_A)) return tsf_pkg::CLS_A;
    if (sig_fits(tsf_pkg::CLS_B)) return tsf_pkg::CLS_B;
    if (sig_fits(tsf_pkg::CLS_C)) return tsf_pkg::CLS_C;
    if (sig_fits(tsf_pkg::CLS_D)) return tsf_pkg::CLS_D;
    if (sig_fits(tsf_pkg::CLS_E)) return tsf_pkg::CLS_E;
    return tsf_pkg::CLS_UNKNOWN;
  endfunction

  task automatic push_fingerprint(input tsf_pkg::tsf_class_e c, input logic done);
    fp_result_t r;
    r.os_class    = c;
    r.classified  = done;
    r.pkt_total   = 32'(ip_cnt);
    r.tcp_total   = 32'(tcp_cnt);
    r.udp_total   = 32'(udp_cnt);
    r.class_total = done ? 32'(class_cnt[int'(c)]) : 32'd0;
    fp_expect_q.push_back(r);
  endtask

  task automatic track_packet(input pkt_event_t ev);
    tsf_pkg::tsf_class_e c;
    if (ev.op == tsf_pkg::OP_HEADER) begin
      capturing = 0;
      ip_cnt++;
      if (ev.proto == tsf_pkg::PROTO_UDP) begin
        udp_cnt++;
      end else if (ev.proto == tsf_pkg::PROTO_TCP) begin
        tcp_cnt++;
        if (ev.syn && !ev.ack) begin
          opt_len = (ev.doff >= 5) ? int'(ev.doff) * 4 - 20 : 0;
          opt_pos = 0;
          if (opt_len == 0) begin
            // SYN without options: unknown right away, in the header's own result
            class_cnt[int'(tsf_pkg::CLS_UNKNOWN)]++;
            push_fingerprint(tsf_pkg::CLS_UNKNOWN, 1'b1);
            return;
          end
          capturing = 1;
        end
      end
      push_fingerprint(tsf_pkg::CLS_UNKNOWN, 1'b0);
    end else if (capturing) begin
      cap_buf[opt_pos] = ev.opt;
      opt_pos = (opt_pos + 1) % 64;
      if (opt_pos >= opt_len) begin
        c = pick_class();
        class_cnt[int'(c)]++;
        capturing = 0;
        push_fingerprint(c, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_header(input logic [7:0] proto, input logic syn, input logic ack,
                              input logic [3:0] doff);
    pkt_event_t ev;
    ev.op    = tsf_pkg::OP_HEADER;
    ev.proto = proto;
    ev.syn   = syn;
    ev.ack   = ack;
    ev.doff  = doff;
    ev.opt   = 8'($urandom);  // don't-care on headers, randomized for bit coverage
    ev.drain = 0;
    ev.calm  = 0;
    stim_q.push_back(ev);
  endtask

  task automatic queue_option(input logic [7:0] b);
    pkt_event_t ev;
    ev.op    = tsf_pkg::OP_OPTION;
    ev.proto = 8'($urandom);
    ev.syn   = 1'($urandom);
    ev.ack   = 1'($urandom);
    ev.doff  = 4'($urandom);
    ev.opt   = b;
    ev.drain = 0;
    ev.calm  = 0;
    stim_q.push_back(ev);
  endtask

  // SYN with options, mostly shaped after one signature, some bytes spoiled, sometimes cut
  // short by the next header; an unshaped SYN gets a random data offset.
  task automatic queue_syn_capture();
    tsf_pkg::tsf_class_e tgt;
    bit         shaped;
    int         len, v, cut;
    logic [3:0] doff;
    logic [7:0] b;
    shaped = 1;
    case ($urandom_range(0, 5))
      0: tgt = tsf_pkg::CLS_A;
      1: tgt = tsf_pkg::CLS_B;
      2: tgt = tsf_pkg::CLS_C;
      3: tgt = tsf_pkg::CLS_D;
      4: tgt = tsf_pkg::CLS_E;
      default: begin
        tgt    = tsf_pkg::CLS_UNKNOWN;
        shaped = 0;
      end
    endcase
    if (shaped) doff = 4'((sig_len(tgt) + 20) / 4);
    else doff = 4'($urandom_range(0, 15));
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b0, doff);
    len = (doff >= 5) ? int'(doff) * 4 - 20 : 0;
    cut = ($urandom_range(0, 11) == 0 && len > 1) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < cut; i++) begin
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
      v = shaped ? tpl_value(tgt, i) : -1;
      if (v >= 0 && $urandom_range(0, 11) != 0) b = 8'(v);
      queue_option(b);
    end
  endtask

  task automatic queue_noise();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      case ($urandom_range(0, 3))
        0:       queue_header(tsf_pkg::PROTO_UDP, 1'($urandom), 1'($urandom), 4'($urandom));
        1:       queue_header(8'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
        default: queue_header(tsf_pkg::PROTO_TCP, 1'($urandom), 1'($urandom), 4'($urandom));
      endcase
    end else begin
      queue_option(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item offered at a time, random idle gaps between some items outside the calm tail.
  // ---------------------------------------------------------------------------
  pkt_event_t cur_ev;
  int         gap_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_packet(cur_ev);
        n_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() > 0 && !(stim_q[0].drain && fp_expect_q.size() > 0)) begin
          cur_ev = stim_q.pop_front();
          if (cur_ev.calm) calm_phase = 1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_ev.opt, cur_ev.doff, cur_ev.ack, cur_ev.syn, cur_ev.proto};
          s_axis_tuser  <= cur_ev.op;
          if (!calm_phase && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, scoreboard, watchdog.
  // ---------------------------------------------------------------------------
  int stall_cnt  = 0;
  int quiet_cnt  = 0;

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    fp_result_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (fp_expect_q.size() == 0) begin
          $error("result with nothing pending: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          e = fp_expect_q.pop_front();
          check_field("os_class",    32'(e.os_class),   32'(m_axis_tdata[2:0]));
          check_field("classified",  32'(e.classified), 32'(m_axis_tuser[0]));
          check_field("pkt_total",   e.pkt_total,       m_axis_tdata[34:3]);
          check_field("tcp_total",   e.tcp_total,       m_axis_tdata[66:35]);
          check_field("udp_total",   e.udp_total,       m_axis_tdata[98:67]);
          check_field("class_total", e.class_total,     m_axis_tdata[130:99]);
          if (e.classified) seen_cls[int'(e.os_class)]++;
        end
      end

      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cnt = 0;
      else quiet_cnt++;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end

      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 4) == 0) stall_cnt = $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset, end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_rand;
    int first_rand;

    // Directed: field extremes, protocol kinds, short data offsets, idle byte,
    // abandoned capture, then a complete class A fingerprint.
    queue_header(8'hFF, 1'b1, 1'b1, 4'hF);
    queue_header(8'h00, 1'b0, 1'b0, 4'h0);
    queue_header(tsf_pkg::PROTO_UDP, 1'b1, 1'b0, 4'd7);
    queue_header(tsf_pkg::PROTO_TCP, 1'b0, 1'b0, 4'd7);
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b1, 4'd7);   // SYN+ACK: no capture
    queue_option(8'hFF);                                  // idle byte, ignored
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b0, 4'd0);   // offset below 5: unknown at once
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b0, 4'd4);
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b0, 4'd5);   // no option bytes
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b0, 4'd15);  // 40-byte capture, dropped below
    queue_option(8'd2);
    queue_option(8'd0);
    queue_option(8'd0);
    queue_header(tsf_pkg::PROTO_TCP, 1'b1, 1'b0, 4'd7);
    queue_option(8'd2);
    queue_option(8'd4);
    queue_option(8'd5);
    queue_option(8'd180);
    queue_option(8'd1);
    queue_option(8'd1);
    queue_option(8'd4);
    queue_option(8'd0);
    queue_option(8'h00);                                  // idle again

    first_rand = stim_q.size();
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      int before_sz;
      before_sz = stim_q.size();
      if ($urandom_range(0, 9) < 7) begin
        queue_syn_capture();
        n_rand += stim_q.size() - before_sz;
      end else begin
        queue_noise();
        if (stim_q[stim_q.size() - 1].op == tsf_pkg::OP_HEADER) n_rand++;
      end
    end

    // Sender waits for a full drain at the start of the random part, midway, and before
    // the calm tail.
    stim_q[first_rand].drain = 1;
    stim_q[(first_rand + stim_q.size()) / 2].drain = 1;
    stim_q[stim_q.size() - CALM_ITEMS].drain = 1;
    for (int i = stim_q.size() - CALM_ITEMS; i < stim_q.size(); i++) stim_q[i].calm = 1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || s_axis_tvalid || fp_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run: %0d items sent, %0d results checked (headers, short offsets, captures).",
             n_items, n_results);
    $display("Fingerprints: unknown %0d, A %0d, B %0d, C %0d, D %0d, E %0d",
             seen_cls[0], seen_cls[1], seen_cls[2], seen_cls[3], seen_cls[4], seen_cls[5]);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
